/* src/jrc_pkg.sv */
// Package: types, constants and arctan table for the rotation constraint unit.
`default_nettype none
package jrc_pkg;
   localparam int SampleWidth         = 16;
   localparam int CordicStagesDefault = 16;
   localparam int MaxStages           = 32;
   localparam int PhaseWidth          = 56;
   localparam int RotWidth            = 36;
   localparam logic signed [PhaseWidth-1:0] HalfPiUnits = 56'sd1073741824;
   localparam logic signed [PhaseWidth-1:0] PiUnits     = 56'sd2147483648;
   localparam logic signed [RotWidth-1:0]   InvGainQ30  = 36'sd652032874;

   typedef struct packed {
      logic signed [SampleWidth-1:0] g00_re;
      logic signed [SampleWidth-1:0] g00_im;
      logic signed [SampleWidth-1:0] g01_re;
      logic signed [SampleWidth-1:0] g01_im;
      logic signed [SampleWidth-1:0] g10_re;
      logic signed [SampleWidth-1:0] g10_im;
      logic signed [SampleWidth-1:0] g11_re;
      logic signed [SampleWidth-1:0] g11_im;
   } req_type;

   typedef struct packed {
      logic signed [15:0] rotation_angle;
      logic signed [15:0] cos_value;
      logic signed [15:0] sin_value;
   } rsp_type;

   function automatic logic signed [PhaseWidth-1:0] atan_units(input int k);
      logic [31:0] t;
      begin
         unique case (k)
            0: t = 32'h20000000; 1: t = 32'h12E4051D; 2: t = 32'h09FB385B;
            3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
            9: t = 32'h00145F2E; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
            15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
            21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
            24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
            default: t = 32'h0;
         endcase
         atan_units = PhaseWidth'(signed'({1'b0, t}));
      end
   endfunction
endpackage
`default_nettype wire

/* src/jones_rotation_constraint_unit.sv */
// Top level: Faraday rotation angle and its cos/sin from a 2x2 complex gain matrix.
//  channel | ports                 | handshake
//  request | start, busy, req_data | accepted when start && !busy
//  result  | rsp_valid, rsp_data   | one-cycle strobe, no backpressure
// One request per cycle; busy is always low. Requests pass through the sum registers,
// the two pipelined CORDIC chains (vectoring, then rotating) and the output register.
// Reset clears the valid pipeline only; data registers are not reset.
`default_nettype none
module jones_rotation_constraint_unit #(
   parameter int CORDIC_STAGES = jrc_pkg::CordicStagesDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire jrc_pkg::req_type req_data,
   output logic                  rsp_valid,
   output jrc_pkg::rsp_type      rsp_data
);
   import jrc_pkg::*;
   localparam int N       = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;
   localparam int SW      = SampleWidth;
   localparam int CW      = SW + 3;
   localparam int Latency = 2 * N + 4;

   logic signed [CW-1:0] ll_re_ff, ll_im_ff, rr_re_ff, rr_im_ff;
   logic signed [CW-1:0] a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im;
   logic signed [PhaseWidth-1:0] ph_ll, ph_rr;
   logic signed [15:0] ang_ff, ang_dly_ff [1:N+1];
   logic signed [15:0] cos_q14, sin_q14;
   logic [Latency:0] valid_ff, valid_in;

   assign busy = 1'b0;

   assign a_re = CW'(signed'(req_data.g00_re[SW-1:0]));
   assign a_im = CW'(signed'(req_data.g00_im[SW-1:0]));
   assign b_re = CW'(signed'(req_data.g01_re[SW-1:0]));
   assign b_im = CW'(signed'(req_data.g01_im[SW-1:0]));
   assign c_re = CW'(signed'(req_data.g10_re[SW-1:0]));
   assign c_im = CW'(signed'(req_data.g10_im[SW-1:0]));
   assign d_re = CW'(signed'(req_data.g11_re[SW-1:0]));
   assign d_im = CW'(signed'(req_data.g11_im[SW-1:0]));

   always_ff @(posedge clock) begin
      ll_re_ff <= a_re + d_re + b_im - c_im;
      ll_im_ff <= a_im + d_im - b_re + c_re;
      rr_re_ff <= a_re + d_re - b_im + c_im;
      rr_im_ff <= a_im + d_im + b_re - c_re;
   end

   jrc_vector_cordic #(.InWidth(CW), .Stages(N)) u_ll (
      .clock(clock), .x_in(ll_re_ff), .y_in(ll_im_ff), .phase(ph_ll));
   jrc_vector_cordic #(.InWidth(CW), .Stages(N)) u_rr (
      .clock(clock), .x_in(rr_re_ff), .y_in(rr_im_ff), .phase(ph_rr));

   always_ff @(posedge clock) begin
      logic signed [PhaseWidth-1:0] d;
      d = (ph_ll - ph_rr + PhaseWidth'(65536)) >>> 17;
      if (d > 32767) ang_ff <= 16'sd32767;
      else if (d < -32768) ang_ff <= -16'sd32768;
      else ang_ff <= 16'(d);
   end

   jrc_rotate_cordic #(.Stages(N)) u_rot (
      .clock(clock), .angle(ang_ff), .cos_q14(cos_q14), .sin_q14(sin_q14));

   for (genvar k = 0; k <= N; k++) begin : g_delay
      if (k == 0) begin : g_first
         always_ff @(posedge clock) ang_dly_ff[1] <= ang_ff;
      end else begin : g_next
         always_ff @(posedge clock) ang_dly_ff[k+1] <= ang_dly_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data.rotation_angle <= ang_dly_ff[N+1];
      rsp_data.cos_value      <= cos_q14;
      rsp_data.sin_value      <= sin_q14;
   end

   assign valid_in = {valid_ff[Latency-1:0], start & ~busy};
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end
   assign rsp_valid = valid_ff[Latency];
endmodule
`default_nettype wire

/* src/jrc_vector_cordic.sv */
// Pipelined vectoring CORDIC: phase of one vector, 2^31 = pi.
`default_nettype none
module jrc_vector_cordic #(
   parameter int InWidth = 20,
   parameter int Stages  = 16
) (
   input  wire logic                         clock,
   input  wire logic signed [InWidth-1:0]    x_in,
   input  wire logic signed [InWidth-1:0]    y_in,
   output logic signed [jrc_pkg::PhaseWidth-1:0] phase
);
   import jrc_pkg::*;
   localparam int W = PhaseWidth;

   logic signed [W-1:0] x_ff [0:Stages];
   logic signed [W-1:0] y_ff [0:Stages];
   logic signed [W-1:0] z_ff [0:Stages];
   logic                zero_ff [0:Stages];
   logic signed [W-1:0] xs_in, ys_in, zs_in;

   always_comb begin
      logic signed [W-1:0] xp, yp;
      xp = W'(x_in) <<< 20;
      yp = W'(y_in) <<< 20;
      if (xp < 0 && yp >= 0) begin
         xs_in = yp; ys_in = -xp; zs_in = HalfPiUnits;
      end else if (xp < 0) begin
         xs_in = -yp; ys_in = xp; zs_in = -HalfPiUnits;
      end else begin
         xs_in = xp; ys_in = yp; zs_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= xs_in;
      y_ff[0]    <= ys_in;
      z_ff[0]    <= zs_in;
      zero_ff[0] <= (x_in == 0) && (y_in == 0);
   end

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      always_ff @(posedge clock) begin
         zero_ff[k+1] <= zero_ff[k];
         if (y_ff[k] > 0) begin
            x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
            y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
            z_ff[k+1] <= z_ff[k] + atan_units(k);
         end else begin
            x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
            y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
            z_ff[k+1] <= z_ff[k] - atan_units(k);
         end
      end
   end

   assign phase = zero_ff[Stages] ? '0 : z_ff[Stages];
endmodule
`default_nettype wire

/* src/jrc_rotate_cordic.sv */
// Pipelined rotating CORDIC: cos and sin of the angle in Q1.14.
`default_nettype none
module jrc_rotate_cordic #(
   parameter int Stages = 16
) (
   input  wire logic               clock,
   input  wire logic signed [15:0] angle,
   output logic signed [15:0]      cos_q14,
   output logic signed [15:0]      sin_q14
);
   import jrc_pkg::*;
   localparam int W = RotWidth;
   localparam int Z = PhaseWidth;

   logic signed [W-1:0] x_ff [0:Stages];
   logic signed [W-1:0] y_ff [0:Stages];
   logic signed [Z-1:0] z_ff [0:Stages];
   logic                flip_ff [0:Stages];
   logic signed [Z-1:0] z0;

   assign z0 = Z'(angle) <<< 16;

   always_ff @(posedge clock) begin
      x_ff[0] <= InvGainQ30;
      y_ff[0] <= '0;
      if (z0 > HalfPiUnits) begin
         z_ff[0] <= z0 - PiUnits; flip_ff[0] <= 1'b1;
      end else if (z0 < -HalfPiUnits) begin
         z_ff[0] <= z0 + PiUnits; flip_ff[0] <= 1'b1;
      end else begin
         z_ff[0] <= z0; flip_ff[0] <= 1'b0;
      end
   end

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      always_ff @(posedge clock) begin
         flip_ff[k+1] <= flip_ff[k];
         if (z_ff[k] >= 0) begin
            x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
            y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
            z_ff[k+1] <= z_ff[k] - atan_units(k);
         end else begin
            x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
            y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
            z_ff[k+1] <= z_ff[k] + atan_units(k);
         end
      end
   end

   function automatic logic signed [15:0] to_q14(input logic signed [W-1:0] v);
      logic signed [W:0] r;
      begin
         r = (W+1)'(v) + (W+1)'(32768);
         r = r >>> 16;
         if (r > 16384) to_q14 = 16'sd16384;
         else if (r < -16384) to_q14 = -16'sd16384;
         else to_q14 = 16'(r);
      end
   endfunction

   always_comb begin
      logic signed [W-1:0] xf, yf;
      xf = flip_ff[Stages] ? -x_ff[Stages] : x_ff[Stages];
      yf = flip_ff[Stages] ? -y_ff[Stages] : y_ff[Stages];
      cos_q14 = to_q14(xf);
      sin_q14 = to_q14(yf);
   end
endmodule
`default_nettype wire

/* src/jrc_checker.sv */
// Port checker for the rotation constraint unit, bound to the top level.
`default_nettype none
module jrc_port_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire jrc_pkg::rsp_type rsp_data
);
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cos_value <= 16384 && rsp_data.cos_value >= -16384))
      else $error("cos out of range");
   a_sin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sin_value <= 16384 && rsp_data.sin_value >= -16384))
      else $error("sin out of range");
endmodule

bind jones_rotation_constraint_unit jrc_port_checker u_jrc_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data));
`default_nettype wire

/* bench/jrc_checker.sv */
// Checker: predicts rotation angle, cos and sin per request and compares results.
`default_nettype none
module jrc_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire jrc_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire jrc_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending
);
   import jrc_pkg::*;

   localparam int Stages = CordicStagesDefault > MaxStages ? MaxStages : CordicStagesDefault;

   rsp_type angle_queue[$];

   function automatic longint arctan_step(input int k);
      longint tbl[32];
      tbl = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
              64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
              64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
              64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
              64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
              64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051,
              64'h00000028, 64'h00000014, 64'h0000000A, 64'h00000005,
              64'h00000002, 64'h00000001, 64'h0, 64'h0};
      return tbl[k];
   endfunction

   function automatic longint vector_phase(input longint x, input longint y);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 1048576;
      y = y * 1048576;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 1073741824;
         end else begin
            t = x; x = -y; y = t; z = -1073741824;
         end
      end
      for (int k = 0; k < Stages; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (y > 0) begin
            x += ys; y -= xs; z += arctan_step(k);
         end else begin
            x -= ys; y += xs; z -= arctan_step(k);
         end
      end
      return z;
   endfunction

   function automatic logic signed [15:0] to_q14(input longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return 16'(r);
   endfunction

   function automatic rsp_type predict_rotation(input req_type g);
      rsp_type res;
      longint ll_re, ll_im, rr_re, rr_im, ang, z, x, y, xs, ys;
      bit flip;
      ll_re = longint'(g.g00_re) + g.g11_re + g.g01_im - g.g10_im;
      ll_im = longint'(g.g00_im) + g.g11_im - g.g01_re + g.g10_re;
      rr_re = longint'(g.g00_re) + g.g11_re - g.g01_im + g.g10_im;
      rr_im = longint'(g.g00_im) + g.g11_im + g.g01_re - g.g10_re;
      ang = (vector_phase(ll_re, ll_im) - vector_phase(rr_re, rr_im) + 65536) >>> 17;
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
      z = ang * 65536;
      flip = 0;
      if (z > 1073741824) begin
         z -= 64'sd2147483648; flip = 1;
      end else if (z < -1073741824) begin
         z += 64'sd2147483648; flip = 1;
      end
      x = 652032874;
      y = 0;
      for (int k = 0; k < Stages; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (z >= 0) begin
            x -= ys; y += xs; z -= arctan_step(k);
         end else begin
            x += ys; y -= xs; z += arctan_step(k);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      res.rotation_angle = 16'(ang);
      res.cos_value = to_q14(x);
      res.sin_value = to_q14(y);
      return res;
   endfunction

   assign pending = angle_queue.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) angle_queue.push_back(predict_rotation(req_data));
         if (rsp_valid) begin
            if (angle_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = angle_queue.pop_front();
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Testbench top: drives matrix requests into the rotation constraint unit and reports.
`default_nettype none
module tb_top;
   import jrc_pkg::*;

   logic    clock, reset, start, busy, rsp_valid;
   req_type req_data;
   rsp_type rsp_data;
   int      fail_count, pending;

   jones_rotation_constraint_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   jrc_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 6)) - 16'd3;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type rand_matrix();
      req_type m;
      logic [15:0] a, b;
      m = req_type'({$urandom, $urandom, $urandom(), $urandom});
      case ($urandom_range(0, 3))
         0: begin
            // pure rotation form: g00=g11, g01=-g10
            a = rand_sample(); b = rand_sample();
            m.g00_re = a; m.g11_re = a; m.g00_im = 0; m.g11_im = 0;
            m.g10_re = b; m.g01_re = -b; m.g10_im = 0; m.g01_im = 0;
         end
         1: begin
            m.g00_re = rand_sample(); m.g00_im = rand_sample();
            m.g01_re = rand_sample(); m.g01_im = rand_sample();
            m.g10_re = rand_sample(); m.g10_im = rand_sample();
            m.g11_re = rand_sample(); m.g11_im = rand_sample();
         end
         default: ;
      endcase
      return m;
   endfunction

   task automatic send_request(input req_type m, input bit gaps);
      if (gaps) begin
         while ($urandom_range(0, 99) < 31) begin
            start <= 0;
            @(posedge clock);
         end
      end
      start    <= 1;
      req_data <= m;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      req_type m;
      int n;
      start    = 0;
      req_data = '0;
      reset    = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero matrix, identity, extremes, negative real axis cases
      send_request('0, 0);
      m = '0; m.g00_re = 16'sd1000; m.g11_re = 16'sd1000;
      send_request(m, 0);
      m = '0; m.g00_re = -16'sd1000; m.g11_re = -16'sd1000;
      send_request(m, 0);
      m = '0; m.g00_re = -16'sd1000; m.g11_re = -16'sd1000; m.g01_im = 16'sd500;
      send_request(m, 0);
      m = '0; m.g10_re = 16'sd4000; m.g01_re = -16'sd4000;
      send_request(m, 0);
      m = '0; m.g10_re = -16'sd4000; m.g01_re = 16'sd4000;
      send_request(m, 0);
      m = '0; m.g01_im = 16'sd7;
      send_request(m, 0);
      m = '0; m.g01_im = 16'sd7; m.g10_im = 16'sd7;
      send_request(m, 0);
      send_request(req_type'({8{16'h7FFF}}), 0);
      send_request(req_type'({8{16'h8000}}), 0);
      send_request(req_type'({4{16'h8000, 16'h7FFF}}), 0);
      send_request(req_type'({4{16'h7FFF, 16'h8000}}), 0);
      m = '0; m.g00_re = 16'h8000; m.g01_im = 16'h8000; m.g10_im = 16'h7FFF;
      send_request(m, 0);
      m = '0; m.g00_re = -16'sd1; m.g11_re = -16'sd1; m.g01_im = 16'sd1;
      m.g10_im = -16'sd1;
      send_request(m, 0);
      m = '0; m.g00_im = 16'sd300; m.g10_re = 16'sd300;
      send_request(m, 0);

      for (n = 0; n < 750; n++) send_request(rand_matrix(), !(n >= 300 && n < 450));
      start <= 0;

      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
